// ===== rtl/trbr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// trbr_pkg: shared types and constants for the trace ring reader
// Operation, status and register codes, beat structs and sequencer states.
// ----------------------------------------------------------------------------
package trbr_pkg;

  localparam int STORE_BYTES_DEF    = 4096;
  localparam int MAX_READ_BYTES_DEF = 64;

  localparam int OP_W     = 3;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 13;
  localparam int RSIZE_W  = 13;
  localparam int PTR_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int MIN_RING = 16;

  localparam logic [OP_W-1:0] OP_WRITE = 3'd0;
  localparam logic [OP_W-1:0] OP_READ  = 3'd1;
  localparam logic [OP_W-1:0] OP_FREE  = 3'd2;
  localparam logic [OP_W-1:0] OP_SEEK  = 3'd3;
  localparam logic [OP_W-1:0] OP_QUERY = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SHORT    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NO_MAGIC = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_RING_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEEK_KEY_LO = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEEK_KEY_HI = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [7:0]       data_in;
    logic [PTR_W-1:0] length;
    logic [PTR_W-1:0] snapshot_read_ptr;
  } in_item_t;

  typedef struct packed {
    logic [7:0]          data_out;
    logic                last;
    logic [STATUS_W-1:0] status;
    logic [FILL_W-1:0]   fill_level;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_MOD, S_WR, S_RA, S_RE, S_SA, S_SD, S_SC, S_EMIT
  } state_t;

endpackage : trbr_pkg
`default_nettype wire

// ===== rtl/trbr_divmod.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// trbr_divmod: serial remainder unit
// Restoring division, one dividend bit per cycle; returns value mod divisor.
// ----------------------------------------------------------------------------
module trbr_divmod #(
  parameter int SW = 13
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic [trbr_pkg::PTR_W-1:0] dividend,
  input  wire logic [SW-1:0]          divisor,
  output logic                        done,
  output logic [SW-1:0]               rem
);

  localparam int CW = $clog2(trbr_pkg::PTR_W + 1);

  logic [trbr_pkg::PTR_W-1:0] quo;
  logic [CW-1:0]              cnt;
  logic                       busy;
  logic [SW:0]                trial;

  assign trial = {rem, quo[trbr_pkg::PTR_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        quo  <= dividend;
        rem  <= '0;
      end else if (busy) begin
        quo <= quo << 1;
        if (trial >= {1'b0, divisor}) begin
          rem <= SW'(trial - {1'b0, divisor});
        end else begin
          rem <= trial[SW-1:0];
        end
        cnt <= cnt + 1'b1;
        if (cnt == CW'(trbr_pkg::PTR_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule : trbr_divmod
`default_nettype wire

// ===== rtl/trbr_store.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// trbr_store: byte store of the ring
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module trbr_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic [7:0]         rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : trbr_store
`default_nettype wire

// ===== rtl/trace_ring_buffer_reader_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// trace_ring_buffer_reader_top: byte trace ring with free-running pointers
// Write, read, free, magic seek and level query over a configurable ring.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | in        | in_valid/in_stall  | in_data  (trbr_pkg::in_item_t)
//  out     | out       | out_valid/out_stall| out_data (trbr_pkg::out_item_t)
//  cfg     | in        | cfg_write          | cfg_index, cfg_data
//
//  One item at a time. Write, read and seek wait on the serial mod unit
//  (32 steps) for the ring offset; a read then emits byte by byte, a seek
//  slides an eight-byte window; query, free and rejected reads emit directly.
//  No clearing pass: the store is undefined until written.
//  Synchronous reset clears pointers, seek keys and handshake state; ring size resets to 4096.
//  A stalled result holds in the output register; the sequencer waits on it.
// ----------------------------------------------------------------------------
module trace_ring_buffer_reader_top #(
  parameter int STORE_BYTES    = trbr_pkg::STORE_BYTES_DEF,
  parameter int MAX_READ_BYTES = trbr_pkg::MAX_READ_BYTES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire trbr_pkg::in_item_t            in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output trbr_pkg::out_item_t                out_data,
  input  wire logic                          cfg_write,
  input  wire logic [trbr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                   cfg_data
);

  localparam int AW = $clog2(STORE_BYTES);
  localparam int SW = $clog2(STORE_BYTES + 1);
  localparam int CW = $clog2(MAX_READ_BYTES + 1);
  localparam int PW = trbr_pkg::PTR_W;

  // registers
  logic [trbr_pkg::RSIZE_W-1:0] ring_size;
  logic [31:0]                  seek_key_lo, seek_key_hi;

  // item and pointer state
  trbr_pkg::state_t state, state_next;
  logic [trbr_pkg::OP_W-1:0]     op_r;
  logic [7:0]                    din_r;
  logic [PW-1:0]                 len_r, snap_r;
  logic [PW-1:0]                 rp, wp;
  logic [AW-1:0]                 off;
  logic [CW-1:0]                 cnt;
  logic [trbr_pkg::STATUS_W-1:0] stat;
  logic [SW-1:0]                 lvl_s, idx;
  logic [3:0]                    nload;
  logic [63:0]                   win;

  // effective ring size, clamped
  logic [PW-1:0] sz32, rs32;
  logic [SW-1:0] sz;
  always_comb begin
    rs32 = PW'(ring_size);
    if (rs32 < PW'(trbr_pkg::MIN_RING)) sz32 = PW'(trbr_pkg::MIN_RING);
    else if (rs32 > PW'(STORE_BYTES))   sz32 = PW'(STORE_BYTES);
    else                                 sz32 = rs32;
    sz = sz32[SW-1:0];
  end

  // level seen from the current read pointer
  logic [PW-1:0] lv_raw, lv_cur;
  assign lv_raw = wp - rp;
  assign lv_cur = (lv_raw > sz32) ? sz32 : lv_raw;

  // read decision
  logic [PW-1:0] rd_start, rd_has;
  logic          rd_short;
  always_comb begin
    if (lv_raw >= sz32) begin
      rd_start = wp - sz32;
      rd_has   = sz32;
    end else begin
      rd_start = rp;
      rd_has   = lv_raw;
    end
    rd_short = (len_r > rd_has) || (lv_raw == '0);
  end

  // free from a snapshot
  logic [PW-1:0] fr_raw, fr_has, fr_cnt, fr_new;
  logic [PW:0]   fr_tgt, fr_cur;
  always_comb begin
    fr_raw = wp - snap_r;
    fr_has = (fr_raw > sz32) ? sz32 : fr_raw;
    fr_cnt = (len_r > fr_has) ? fr_has : len_r;
    fr_new = snap_r + fr_cnt;
    fr_tgt = {1'b0, snap_r} + {1'b0, fr_cnt};
    fr_cur = {(snap_r > rp), rp};
  end

  // offset step with wrap
  logic [SW-1:0] off_inc;
  logic [AW-1:0] off_adv;
  assign off_inc = SW'(off) + 1'b1;
  assign off_adv = (off_inc == sz) ? '0 : off_inc[AW-1:0];

  // serial mod unit
  logic          mod_start, mod_done;
  logic [PW-1:0] mod_in;
  logic [SW-1:0] mod_rem;

  trbr_divmod #(.SW(SW)) u_divmod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (mod_in),
    .divisor  (sz),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // byte store
  logic       st_we, st_re;
  logic [7:0] st_rdata;

  trbr_store #(.DEPTH(STORE_BYTES), .AW(AW)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (off),
    .wdata (din_r),
    .re    (st_re),
    .raddr (off),
    .rdata (st_rdata)
  );

  // output register
  logic                out_free, out_load;
  trbr_pkg::out_item_t out_next;
  assign out_free = !out_valid || !out_stall;

  logic seek_hit, seek_end;
  assign seek_hit = (win == {seek_key_hi, seek_key_lo});
  assign seek_end = (idx == lvl_s - SW'(8));

  assign in_stall = (state != trbr_pkg::S_IDLE);

  // sequencer
  always_comb begin
    state_next = state;
    mod_start  = 1'b0;
    mod_in     = rp;
    st_we      = 1'b0;
    st_re      = 1'b0;
    out_load   = 1'b0;
    out_next.data_out   = 8'd0;
    out_next.last       = 1'b1;
    out_next.status     = stat;
    out_next.fill_level = trbr_pkg::FILL_W'(lv_cur);
    unique case (state)
      trbr_pkg::S_IDLE: begin
        if (in_valid) state_next = trbr_pkg::S_DEC;
      end
      trbr_pkg::S_DEC: begin
        state_next = trbr_pkg::S_EMIT;
        if (op_r == trbr_pkg::OP_WRITE) begin
          mod_start  = 1'b1;
          mod_in     = wp;
          state_next = trbr_pkg::S_MOD;
        end else if (op_r == trbr_pkg::OP_READ) begin
          if (len_r <= PW'(MAX_READ_BYTES) && !rd_short && len_r != '0) begin
            mod_start  = 1'b1;
            mod_in     = rd_start;
            state_next = trbr_pkg::S_MOD;
          end
        end else if (op_r == trbr_pkg::OP_SEEK) begin
          if (lv_cur >= PW'(8)) begin
            mod_start  = 1'b1;
            mod_in     = rp;
            state_next = trbr_pkg::S_MOD;
          end
        end
      end
      trbr_pkg::S_MOD: begin
        if (mod_done) begin
          if (op_r == trbr_pkg::OP_WRITE)     state_next = trbr_pkg::S_WR;
          else if (op_r == trbr_pkg::OP_READ) state_next = trbr_pkg::S_RA;
          else                                state_next = trbr_pkg::S_SA;
        end
      end
      trbr_pkg::S_WR: begin
        st_we      = 1'b1;
        state_next = trbr_pkg::S_EMIT;
      end
      trbr_pkg::S_RA: begin
        st_re      = 1'b1;
        state_next = trbr_pkg::S_RE;
      end
      trbr_pkg::S_RE: begin
        out_next.data_out = st_rdata;
        out_next.last     = (PW'(cnt) + 1'b1 == len_r);
        out_next.status   = trbr_pkg::ST_OK;
        if (out_free) begin
          out_load   = 1'b1;
          state_next = out_next.last ? trbr_pkg::S_IDLE : trbr_pkg::S_RA;
        end
      end
      trbr_pkg::S_SA: begin
        st_re      = 1'b1;
        state_next = trbr_pkg::S_SD;
      end
      trbr_pkg::S_SD: begin
        state_next = (nload >= 4'd7) ? trbr_pkg::S_SC : trbr_pkg::S_SA;
      end
      trbr_pkg::S_SC: begin
        if (seek_hit || seek_end) state_next = trbr_pkg::S_EMIT;
        else                      state_next = trbr_pkg::S_SA;
      end
      trbr_pkg::S_EMIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = trbr_pkg::S_IDLE;
        end
      end
      default: state_next = trbr_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= trbr_pkg::S_IDLE;
    else     state <= state_next;
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_size   <= trbr_pkg::RSIZE_W'(4096);
      seek_key_lo <= '0;
      seek_key_hi <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        trbr_pkg::REG_RING_SIZE:   ring_size   <= cfg_data[trbr_pkg::RSIZE_W-1:0];
        trbr_pkg::REG_SEEK_KEY_LO: seek_key_lo <= cfg_data;
        trbr_pkg::REG_SEEK_KEY_HI: seek_key_hi <= cfg_data;
        default: ;
      endcase
    end
  end

  // pointers and work registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rp <= '0;
      wp <= '0;
    end else begin
      unique case (state)
        trbr_pkg::S_IDLE: begin
          if (in_valid) begin
            op_r   <= in_data.op;
            din_r  <= in_data.data_in;
            len_r  <= in_data.length;
            snap_r <= in_data.snapshot_read_ptr;
          end
        end
        trbr_pkg::S_DEC: begin
          stat  <= trbr_pkg::ST_OK;
          cnt   <= '0;
          nload <= '0;
          idx   <= '0;
          lvl_s <= SW'(lv_cur);
          if (op_r == trbr_pkg::OP_READ) begin
            if (len_r > PW'(MAX_READ_BYTES)) begin
              stat <= trbr_pkg::ST_TOO_LONG;
            end else if (rd_short) begin
              stat <= trbr_pkg::ST_SHORT;
            end else begin
              rp <= rd_start + len_r;
            end
          end else if (op_r == trbr_pkg::OP_FREE) begin
            if (snap_r == rp)        rp <= rp + fr_cnt;
            else if (fr_tgt > fr_cur) rp <= fr_new;
          end else if (op_r == trbr_pkg::OP_SEEK) begin
            if (lv_cur < PW'(8)) begin
              rp   <= rp + lv_cur;
              stat <= trbr_pkg::ST_NO_MAGIC;
            end
          end
        end
        trbr_pkg::S_MOD: begin
          if (mod_done) off <= mod_rem[AW-1:0];
        end
        trbr_pkg::S_WR: begin
          wp <= wp + 1'b1;
        end
        trbr_pkg::S_RA: begin
          off <= off_adv;
        end
        trbr_pkg::S_RE: begin
          if (out_free) cnt <= cnt + 1'b1;
        end
        trbr_pkg::S_SA: begin
          off <= off_adv;
        end
        trbr_pkg::S_SD: begin
          win <= {st_rdata, win[63:8]};
          if (nload != 4'd8) nload <= nload + 1'b1;
          else               idx   <= idx + 1'b1;
        end
        trbr_pkg::S_SC: begin
          if (seek_hit) begin
            rp <= rp + PW'(idx);
          end else if (seek_end) begin
            rp   <= rp + PW'(lvl_s);
            stat <= trbr_pkg::ST_NO_MAGIC;
          end
        end
        trbr_pkg::S_EMIT: ;
        default: ;
      endcase
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_data <= out_next;
  end

endmodule : trace_ring_buffer_reader_top
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: trace ring reader check
// Drives write/read/free/seek/query beats with random gaps, predicts every
// result beat in a local ring model and compares them field by field.
// ----------------------------------------------------------------------------

// Scoreboard: ring model state plus the queue of expected result beats.
class ring_scoreboard;
  logic [7:0]  bytes_q [4096];
  logic [31:0] rd_ptr, wr_ptr;
  logic [12:0] ring_len;
  logic [31:0] key_lo, key_hi;
  trbr_pkg::out_item_t pending_q [$];
  int          errors;

  function void clear();
    rd_ptr = 32'd0; wr_ptr = 32'd0; ring_len = 13'd4096; key_lo = 32'd0; key_hi = 32'd0;
    pending_q.delete(); errors = 0;
  endfunction

  function logic [31:0] span();
    logic [31:0] s;
    s = 32'(ring_len);
    if (s < 16) s = 32'd16;
    if (s > 4096) s = 32'd4096;
    return s;
  endfunction

  function logic [31:0] level_of(logic [31:0] p);
    logic [31:0] lv;
    lv = wr_ptr - p;
    return (lv > span()) ? span() : lv;
  endfunction

  function logic [7:0] byte_at(logic [31:0] p);
    return bytes_q[p % span()];
  endfunction

  function void push(logic [7:0] d, logic l, logic [1:0] st);
    trbr_pkg::out_item_t r;
    r.data_out = d; r.last = l; r.status = st;
    r.fill_level = 13'(level_of(rd_ptr));
    pending_q.push_back(r);
  endfunction

  function void set_reg(logic [1:0] idx, logic [31:0] v);
    case (idx)
      trbr_pkg::REG_RING_SIZE:   ring_len = v[12:0];
      trbr_pkg::REG_SEEK_KEY_LO: key_lo = v;
      trbr_pkg::REG_SEEK_KEY_HI: key_hi = v;
      default: ;
    endcase
  endfunction

  function void release_bytes(logic [31:0] snap, logic [31:0] cnt);
    logic [32:0] tgt, cur;
    if (cnt > level_of(snap)) cnt = level_of(snap);
    if (snap != rd_ptr) begin
      tgt = {1'b0, snap} + {1'b0, cnt};
      cur = {1'b0, rd_ptr};
      if (snap > rd_ptr) cur = cur + 33'h1_0000_0000;
      if (tgt > cur) rd_ptr = snap + cnt;
    end else begin
      rd_ptr = rd_ptr + cnt;
    end
  endfunction

  // Accepted input beat: update the model and queue its result beats.
  function void note_item(trbr_pkg::in_item_t it);
    logic [31:0] s, start, has, base, skip, i;
    logic [63:0] want, win;
    logic [1:0]  st;
    st = trbr_pkg::ST_OK;
    case (it.op)
      trbr_pkg::OP_WRITE: begin
        bytes_q[wr_ptr % span()] = it.data_in;
        wr_ptr = wr_ptr + 32'd1;
      end
      trbr_pkg::OP_READ: begin
        s = span(); start = rd_ptr; has = wr_ptr - rd_ptr;
        if (it.length > 64) begin
          push(8'd0, 1'b1, trbr_pkg::ST_TOO_LONG);
          return;
        end
        // overrun: start jumps to one ring behind the writer
        if (has >= s) begin
          has = s; start = wr_ptr - s;
        end
        if (it.length > has || wr_ptr == start) begin
          push(8'd0, 1'b1, trbr_pkg::ST_SHORT);
          return;
        end
        rd_ptr = start + it.length;
        if (it.length == 0) push(8'd0, 1'b1, trbr_pkg::ST_OK);
        for (i = 0; i < it.length; i++)
          push(byte_at(start + i), i + 1 == it.length, trbr_pkg::ST_OK);
        return;
      end
      trbr_pkg::OP_FREE: release_bytes(it.snapshot_read_ptr, it.length);
      trbr_pkg::OP_SEEK: begin
        base = rd_ptr; has = level_of(base); skip = has; st = trbr_pkg::ST_NO_MAGIC;
        if (has >= 8) begin
          want = {key_hi, key_lo}; win = 64'd0;
          for (i = 0; i < 8; i++) win |= 64'(byte_at(base + i)) << (8 * i);
          for (i = 0; ; i++) begin
            if (win == want) begin
              skip = i; st = trbr_pkg::ST_OK;
              break;
            end
            if (i == has - 8) break;
            win = (win >> 8) | (64'(byte_at(base + i + 8)) << 56);
          end
        end
        if (skip != 0) release_bytes(base, skip);
      end
      default: ;
    endcase
    push(8'd0, 1'b1, st);
  endfunction

  function void check_beat(trbr_pkg::out_item_t got);
    trbr_pkg::out_item_t e;
    if (pending_q.size() == 0) begin
      $error("unexpected result beat %h", got);
      errors++;
      return;
    end
    e = pending_q.pop_front();
    if (got.data_out !== e.data_out) begin
      $error("data_out exp %h got %h", e.data_out, got.data_out); errors++;
    end
    if (got.last !== e.last) begin
      $error("last exp %b got %b", e.last, got.last); errors++;
    end
    if (got.status !== e.status) begin
      $error("status exp %0d got %0d", e.status, got.status); errors++;
    end
    if (got.fill_level !== e.fill_level) begin
      $error("fill_level exp %0d got %0d", e.fill_level, got.fill_level); errors++;
    end
  endfunction
endclass

module testbench;
  logic      clk, rst;
  logic      in_valid, in_stall, out_valid, out_stall;
  trbr_pkg::in_item_t  in_data;
  trbr_pkg::out_item_t out_data;
  logic      cfg_write;
  logic [trbr_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  ring_scoreboard ring_sb;
  int  idle_cycles;        // cycles with no beat on either channel
  bit  hold_off;           // long receiver stall requested

  localparam int WATCHDOG_LIMIT = 20000;

  trace_ring_buffer_reader_top uut (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cfg_write, .cfg_index, .cfg_data
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stall per beat, or a long hold-off when asked.
  initial begin
    int gap;
    out_stall = 1;
    @(posedge clk iff !rst);
    forever begin
      if (hold_off) begin
        out_stall <= 1;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
        out_stall <= 1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Result checker: samples at the edge where the beat is taken.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) ring_sb.check_beat(out_data);
  end

  // Watchdog on cycles with nothing accepted.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL trace_ring_buffer_reader_top");
        $finish;
      end
    end
  end

  // Offer one input beat after a random gap, note it when accepted.
  // Valid stays up after the beat; the next call or a pause drops it.
  task automatic send_item(trbr_pkg::in_item_t it, bit no_gap = 0);
    int gap;
    gap = (no_gap || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ring_sb.note_item(it);
  endtask

  task automatic send_op(logic [trbr_pkg::OP_W-1:0] op, logic [7:0] d = 8'd0,
                         logic [31:0] len = 32'd0, logic [31:0] snap = 32'd0);
    trbr_pkg::in_item_t it;
    it.op = op; it.data_in = d; it.length = len; it.snapshot_read_ptr = snap;
    send_item(it);
  endtask

  // Drain, allow the sequencer to settle, then write a register.
  task automatic write_reg(logic [1:0] idx, logic [31:0] v);
    in_valid <= 0;
    while (ring_sb.pending_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    cfg_write <= 1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    cfg_write <= 0;
    ring_sb.set_reg(idx, v);
  endtask

  // New ring size, then skip any overrun and free the rest, so that every
  // later read lands on bytes written under this size.
  task automatic resize_ring(logic [31:0] v);
    write_reg(trbr_pkg::REG_RING_SIZE, v);
    send_op(trbr_pkg::OP_READ, 8'd0, 32'd0);
    send_op(trbr_pkg::OP_FREE, 8'd0, 32'hFFFF_FFFF, ring_sb.rd_ptr);
  endtask

  task automatic write_magic(logic [63:0] m);
    int k;
    for (k = 0; k < 8; k++) send_op(trbr_pkg::OP_WRITE, m[8*k +: 8]);
  endtask

  // Random phase: mostly writes and short reads, with seeks and frees.
  task automatic random_phase(int n);
    int k, sel;
    trbr_pkg::in_item_t it;
    for (k = 0; k < n; k++) begin
      sel = $urandom_range(0, 99);
      it.op = trbr_pkg::OP_WRITE; it.data_in = 8'($urandom); it.length = 32'd0;
      it.snapshot_read_ptr = $urandom;
      if (sel < 45) begin
        it.op = trbr_pkg::OP_WRITE;
      end else if (sel < 70) begin
        it.op = trbr_pkg::OP_READ;
        it.length = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 12);
      end else if (sel < 80) begin
        it.op = trbr_pkg::OP_FREE;
        it.length = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 20);
        // current or stale snapshot, never ahead of the reader
        case ($urandom_range(0, 1))
          0: it.snapshot_read_ptr = ring_sb.rd_ptr;
          default: it.snapshot_read_ptr = ring_sb.rd_ptr - $urandom_range(0, 8);
        endcase
      end else if (sel < 86) begin
        if ($urandom_range(0, 1)) write_magic({ring_sb.key_hi, ring_sb.key_lo});
        it.op = trbr_pkg::OP_SEEK;
      end else begin
        it.op = 3'($urandom_range(4, 7));
      end
      send_item(it);
    end
  endtask

  initial begin
    int k;
    ring_sb = new();
    ring_sb.clear();
    rst = 1; in_valid = 0; in_data = '0; cfg_write = 0; cfg_index = '0;
    cfg_data = '0; hold_off = 0;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: empty ring reads, extremes, frees, seeks, odd op codes.
    send_op(trbr_pkg::OP_READ, 8'd0, 32'd0);
    send_op(trbr_pkg::OP_READ, 8'd0, 32'hFFFF_FFFF);
    send_op(trbr_pkg::OP_SEEK);
    send_op('1);
    send_op(trbr_pkg::OP_WRITE, 8'h00);
    send_op(trbr_pkg::OP_WRITE, 8'hFF);
    send_op(trbr_pkg::OP_READ, 8'd0, 32'd65);
    send_op(trbr_pkg::OP_READ, 8'd0, 32'd3);
    send_op(trbr_pkg::OP_READ, 8'd0, 32'd0);
    send_op(trbr_pkg::OP_READ, 8'd0, 32'd2);
    send_op(trbr_pkg::OP_FREE, 8'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    write_reg(trbr_pkg::REG_SEEK_KEY_LO, 32'h0403_0201);
    write_reg(trbr_pkg::REG_SEEK_KEY_HI, 32'h0807_0605);
    send_op(trbr_pkg::OP_WRITE, 8'hAA);
    write_magic(64'h0807_0605_0403_0201);
    send_op(trbr_pkg::OP_SEEK);
    send_op(trbr_pkg::OP_READ, 8'd0, 32'd8);
    send_op(trbr_pkg::OP_QUERY);

    // Smallest ring: overrun the ring, then read across the wrap.
    resize_ring(32'd16);
    for (k = 0; k < 40; k++) send_op(trbr_pkg::OP_WRITE, 8'($urandom));
    send_op(trbr_pkg::OP_READ, 8'd0, 32'd16);
    random_phase(40);

    // Receiver holds off while the sender keeps offering beats.
    hold_off = 1;
    for (k = 0; k < 12; k++) send_item('{op: trbr_pkg::OP_WRITE, data_in: 8'($urandom),
                                       length: 32'd0, snapshot_read_ptr: 32'd0}, 1);
    for (k = 0; k < 4; k++) send_item('{op: trbr_pkg::OP_READ, data_in: 8'd0,
                                       length: 32'd4, snapshot_read_ptr: 32'd0}, 1);

    // Out-of-range sizes clamp; then a mid ring and random magic.
    resize_ring(32'd3);
    random_phase(30);
    resize_ring(32'h1FFF);
    random_phase(30);
    resize_ring(32'd100);
    write_reg(trbr_pkg::REG_SEEK_KEY_LO, $urandom);
    write_reg(trbr_pkg::REG_SEEK_KEY_HI, $urandom);
    random_phase(35);
    resize_ring(32'd4096);
    write_reg(trbr_pkg::REG_SEEK_KEY_LO, 32'hFFFF_FFFF);
    write_reg(trbr_pkg::REG_SEEK_KEY_HI, 32'hFFFF_FFFF);
    random_phase(35);

    in_valid <= 0;
    while (ring_sb.pending_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (ring_sb.errors == 0 && ring_sb.pending_q.size() == 0) begin
      $display("PASS trace_ring_buffer_reader_top");
    end else begin
      $display("FAIL trace_ring_buffer_reader_top");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/trbr_pkg.sv
rtl/trbr_divmod.sv
rtl/trbr_store.sv
rtl/trace_ring_buffer_reader_top.sv
tb/sv/testbench.sv
